// ----- rtl/lz4_block_decompressor_unit_defines.svh -----
// Assertion macros shared by the LZ4 block decompressor RTL.
`ifndef LZ4_BLOCK_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZ4_BLOCK_DECOMPRESSOR_UNIT_DEFINES_SVH
`ifndef SYNTH
`define LZ4BD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LZ4BD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define LZ4BD_ASSERT(label, prop, msg)
`define LZ4BD_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

// ----- rtl/lz4bd_pkg.sv -----
// Types and constants shared by the LZ4 block decompressor modules.
package lz4bd_pkg;

    typedef enum logic [1:0] {
        FN_DICT   = 2'd0,
        FN_BYTE   = 2'd1,
        FN_TICK   = 2'd2,
        FN_FINISH = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_OFFSET = 2'd1,
        ST_TRUNCATED  = 2'd2,
        ST_REFUSED    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_TOKEN     = 4'd0,
        PH_LIT_EXT   = 4'd1,
        PH_LITERALS  = 4'd2,
        PH_OFF_LO    = 4'd3,
        PH_OFF_HI    = 4'd4,
        PH_MATCH_EXT = 4'd5,
        PH_COPY      = 4'd6,
        PH_PAD       = 4'd7,
        PH_DONE      = 4'd8
    } phase_t;

    typedef struct packed {
        logic    valid;
        logic    has_byte;
        logic    is_padding;
        logic    done_res;
        status_t status;
    } res_flags_t;

    localparam logic [3:0] LIT_EXT_NIBBLE  = 4'd15;
    localparam logic [3:0] MIN_MATCH       = 4'd4;
    localparam logic [7:0] EXT_CONT        = 8'd255;
    localparam logic [7:0] PAD_BYTE        = 8'hFF;
    localparam logic [3:0] PAGE_LOG2_MAX   = 4'd12;
    localparam logic [3:0] PAGE_LOG2_RESET = 4'd8;
    localparam logic [2:0] CFG_ADDR_PAGE   = 3'd0;

endpackage

// ----- rtl/lz4bd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lz4bd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/lz4bd_cfg.sv -----
// APB register block holding the padding page size.
module lz4bd_cfg
    import lz4bd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [3:0]  page_size_log2
);

    logic [3:0] page_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == CFG_ADDR_PAGE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg <= PAGE_LOG2_RESET;
        end
        else if (wr_en)
        begin
            page_reg <= pwdata[3:0];
        end
    end

    assign prdata         = (paddr == CFG_ADDR_PAGE) ? {28'd0, page_reg} : 32'd0;
    assign page_size_log2 = page_reg;

endmodule

// ----- rtl/lz4bd_core.sv -----
// Parser state, history ring and per-beat decode logic of the decompressor.
`include "lz4_block_decompressor_unit_defines.svh"
module lz4bd_core
    import lz4bd_pkg::*;
#(
    parameter int WINDOW_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  proc_en,
    input  func_t                 func,
    input  logic [7:0]            data_byte,
    input  logic [3:0]            page_size_log2,
    output logic [7:0]            res_byte,
    output logic [COUNT_BITS-1:0] res_position,
    output logic [COUNT_BITS-1:0] res_total,
    output res_flags_t            res_flags
);

    localparam int HIST_DEPTH = 1 << WINDOW_BITS;
    localparam logic [WINDOW_BITS:0] FILL_FULL = {1'b1, {WINDOW_BITS{1'b0}}};

    phase_t                 phase_reg, phase_next;
    logic [WINDOW_BITS:0]   fill_reg, fill_next;
    logic [WINDOW_BITS-1:0] wp_reg, wp_next;
    logic [3:0]             nibble_reg, nibble_next;
    logic [COUNT_BITS-1:0]  rem_reg, rem_next;
    logic [7:0]             off_lo_reg, off_lo_next;
    logic [WINDOW_BITS-1:0] dist_reg, dist_next;
    logic                   copy_ok_reg, copy_ok_next;
    logic [COUNT_BITS-1:0]  outcnt_reg, outcnt_next;
    logic [COUNT_BITS-1:0]  saved_reg, saved_next;
    logic                   trunc_reg, trunc_next;
    logic                   byp_hit_reg;
    logic [7:0]             byp_data_reg;

    logic                   hist_we;
    logic [7:0]             hist_wdata;
    logic                   cnt_inc;
    logic [WINDOW_BITS-1:0] rd_addr;
    logic [7:0]             ram_rdata;
    logic [7:0]             copy_byte;
    logic [COUNT_BITS:0]    rem_sum;
    logic [COUNT_BITS-1:0]  rem_ext;
    logic [COUNT_BITS-1:0]  rem_dec;
    logic [15:0]            dist_full;
    logic                   dist_ok;
    logic [3:0]             page_lg;
    logic [COUNT_BITS-1:0]  pad_mask;
    logic                   pad_needed;
    logic                   trunc_now;

    assign rem_sum   = {1'b0, rem_reg} + (COUNT_BITS+1)'(data_byte);
    assign rem_ext   = rem_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : rem_sum[COUNT_BITS-1:0];
    assign rem_dec   = (rem_reg == '0) ? '0 : rem_reg - COUNT_BITS'(1);
    assign dist_full = {data_byte, off_lo_reg};
    assign dist_ok   = (dist_full != 16'd0) && ({1'b0, dist_full} <= 17'(fill_reg));
    assign page_lg   = (page_size_log2 > PAGE_LOG2_MAX) ? PAGE_LOG2_MAX : page_size_log2;
    assign pad_mask  = ~({COUNT_BITS{1'b1}} << page_lg);
    assign pad_needed = |(outcnt_reg & pad_mask);
    assign trunc_now = trunc_reg || ((phase_reg != PH_TOKEN) && (phase_reg != PH_OFF_LO));
    assign copy_byte = byp_hit_reg ? byp_data_reg : ram_rdata;

    // Next parse phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (proc_en)
        begin
            unique case (phase_reg)
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                PH_PAD:
                begin
                    if (func == FN_TICK && !pad_needed)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_COPY:
                begin
                    if (func == FN_TICK && rem_dec == '0)
                    begin
                        phase_next = PH_TOKEN;
                    end
                end
                default:
                begin
                    priority if (func == FN_FINISH)
                    begin
                        phase_next = pad_needed ? PH_PAD : PH_DONE;
                    end
                    else if (func == FN_BYTE)
                    begin
                        unique case (phase_reg)
                            PH_TOKEN:
                            begin
                                priority if (data_byte[7:4] == LIT_EXT_NIBBLE)
                                begin
                                    phase_next = PH_LIT_EXT;
                                end
                                else if (data_byte[7:4] == 4'd0)
                                begin
                                    phase_next = PH_OFF_LO;
                                end
                                else
                                begin
                                    phase_next = PH_LITERALS;
                                end
                            end
                            PH_LIT_EXT:
                            begin
                                if (data_byte != EXT_CONT)
                                begin
                                    phase_next = PH_LITERALS;
                                end
                            end
                            PH_LITERALS:
                            begin
                                if (rem_dec == '0)
                                begin
                                    phase_next = PH_OFF_LO;
                                end
                            end
                            PH_OFF_LO:
                            begin
                                phase_next = PH_OFF_HI;
                            end
                            PH_OFF_HI:
                            begin
                                priority if (nibble_reg == LIT_EXT_NIBBLE)
                                begin
                                    phase_next = PH_MATCH_EXT;
                                end
                                else
                                begin
                                    phase_next = dist_ok ? PH_COPY : PH_TOKEN;
                                end
                            end
                            PH_MATCH_EXT:
                            begin
                                if (data_byte != EXT_CONT)
                                begin
                                    phase_next = copy_ok_reg ? PH_COPY : PH_TOKEN;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_TOKEN;
                            end
                        endcase
                    end
                    else
                    begin
                        phase_next = phase_reg;
                    end
                end
            endcase
        end
    end

    // Datapath updates and the result of the beat.
    always_comb
    begin
        fill_next    = fill_reg;
        wp_next      = wp_reg;
        nibble_next  = nibble_reg;
        rem_next     = rem_reg;
        off_lo_next  = off_lo_reg;
        dist_next    = dist_reg;
        copy_ok_next = copy_ok_reg;
        saved_next   = saved_reg;
        trunc_next   = trunc_reg;
        hist_we      = 1'b0;
        hist_wdata   = data_byte;
        cnt_inc      = 1'b0;
        res_byte     = 8'd0;
        res_position = '0;
        res_total    = '0;
        res_flags    = '{valid: 1'b0, has_byte: 1'b0, is_padding: 1'b0,
                         done_res: 1'b0, status: ST_OK};
        if (proc_en)
        begin
            unique case (phase_reg)
                PH_DONE:
                begin
                    res_flags.valid = 1'b0;
                end
                PH_PAD:
                begin
                    if (func == FN_TICK)
                    begin
                        if (pad_needed)
                        begin
                            res_flags.valid      = 1'b1;
                            res_flags.has_byte   = 1'b1;
                            res_flags.is_padding = 1'b1;
                            res_byte             = PAD_BYTE;
                            res_position         = outcnt_reg;
                            cnt_inc              = 1'b1;
                        end
                        else
                        begin
                            res_flags.valid    = 1'b1;
                            res_flags.done_res = 1'b1;
                            res_flags.status   = trunc_reg ? ST_TRUNCATED : ST_OK;
                            res_total          = saved_reg;
                        end
                    end
                end
                PH_COPY:
                begin
                    if (func == FN_TICK)
                    begin
                        res_flags.valid    = 1'b1;
                        res_flags.has_byte = 1'b1;
                        res_byte           = copy_byte;
                        res_position       = outcnt_reg;
                        hist_we            = 1'b1;
                        hist_wdata         = copy_byte;
                        cnt_inc            = 1'b1;
                        rem_next           = rem_dec;
                    end
                    else
                    begin
                        res_flags.valid  = 1'b1;
                        res_flags.status = ST_REFUSED;
                    end
                end
                default:
                begin
                    unique case (func)
                        FN_TICK:
                        begin
                            res_flags.valid = 1'b0;
                        end
                        FN_DICT:
                        begin
                            if (phase_reg == PH_TOKEN && outcnt_reg == '0)
                            begin
                                hist_we = 1'b1;
                            end
                        end
                        FN_FINISH:
                        begin
                            trunc_next = trunc_now;
                            saved_next = outcnt_reg;
                            if (pad_needed)
                            begin
                                res_flags.valid      = 1'b1;
                                res_flags.has_byte   = 1'b1;
                                res_flags.is_padding = 1'b1;
                                res_byte             = PAD_BYTE;
                                res_position         = outcnt_reg;
                                cnt_inc              = 1'b1;
                            end
                            else
                            begin
                                res_flags.valid    = 1'b1;
                                res_flags.done_res = 1'b1;
                                res_flags.status   = trunc_now ? ST_TRUNCATED : ST_OK;
                                res_total          = outcnt_reg;
                            end
                        end
                        FN_BYTE:
                        begin
                            unique case (phase_reg)
                                PH_TOKEN:
                                begin
                                    nibble_next = data_byte[3:0];
                                    rem_next    = COUNT_BITS'(data_byte[7:4]);
                                end
                                PH_LIT_EXT, PH_MATCH_EXT:
                                begin
                                    rem_next = rem_ext;
                                end
                                PH_LITERALS:
                                begin
                                    res_flags.valid    = 1'b1;
                                    res_flags.has_byte = 1'b1;
                                    res_byte           = data_byte;
                                    res_position       = outcnt_reg;
                                    hist_we            = 1'b1;
                                    cnt_inc            = 1'b1;
                                    rem_next           = rem_dec;
                                end
                                PH_OFF_LO:
                                begin
                                    off_lo_next = data_byte;
                                end
                                PH_OFF_HI:
                                begin
                                    dist_next    = dist_full[WINDOW_BITS-1:0];
                                    copy_ok_next = dist_ok;
                                    rem_next     = COUNT_BITS'(nibble_reg) +
                                                   COUNT_BITS'(MIN_MATCH);
                                    if (!dist_ok)
                                    begin
                                        res_flags.valid  = 1'b1;
                                        res_flags.status = ST_BAD_OFFSET;
                                    end
                                end
                                default:
                                begin
                                    rem_next = rem_reg;
                                end
                            endcase
                        end
                    endcase
                end
            endcase
        end
        if (hist_we)
        begin
            wp_next   = wp_reg + WINDOW_BITS'(1);
            fill_next = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + (WINDOW_BITS+1)'(1);
        end
    end

    assign outcnt_next = cnt_inc ? outcnt_reg + COUNT_BITS'(1) : outcnt_reg;

    // The read always targets the copy source of the state that follows this beat.
    assign rd_addr = wp_next - dist_next;

    lz4bd_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wp_reg),
        .wdata (hist_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TOKEN;
            fill_reg    <= '0;
            wp_reg      <= '0;
            nibble_reg  <= '0;
            rem_reg     <= '0;
            off_lo_reg  <= '0;
            dist_reg    <= '0;
            copy_ok_reg <= 1'b0;
            outcnt_reg  <= '0;
            saved_reg   <= '0;
            trunc_reg   <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            fill_reg    <= fill_next;
            wp_reg      <= wp_next;
            nibble_reg  <= nibble_next;
            rem_reg     <= rem_next;
            off_lo_reg  <= off_lo_next;
            dist_reg    <= dist_next;
            copy_ok_reg <= copy_ok_next;
            outcnt_reg  <= outcnt_next;
            saved_reg   <= saved_next;
            trunc_reg   <= trunc_next;
            byp_hit_reg <= hist_we && (wp_reg == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= hist_wdata;
    end

    `LZ4BD_ASSERT(a_fill_bound, fill_reg <= FILL_FULL, "History fill count exceeds the ring depth.")
    `LZ4BD_ASSERT_IMPL(a_copy_has_work, phase_reg == PH_COPY, rem_reg != '0, "Copy phase with no bytes left.")
    `LZ4BD_ASSERT_IMPL(a_done_quiet, proc_en && phase_reg == PH_DONE, !res_flags.valid, "Result produced after the final result.")
    `LZ4BD_ASSERT_IMPL(a_byte_not_done, res_flags.has_byte, res_flags.valid && !res_flags.done_res, "Byte result marked as final.")

endmodule

// ----- rtl/lz4_block_decompressor_unit.sv -----
// Top level: beats enter an input register, are decoded in one pass and leave from a result register.
// An accepted beat is held in the input register; its result is registered and drives m_tvalid.
// Throughput: one input beat per cycle; the input stalls only while a result waits on m_tready.
// Reset: rst_n clears all control state asynchronously; page_size_log2 returns to 8.
// The history RAM needs no clearing pass; the block accepts beats right after reset.
`include "lz4_block_decompressor_unit_defines.svh"
module lz4_block_decompressor_unit
    import lz4bd_pkg::*;
#(
    parameter int WINDOW_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [7:0]                                    s_tdata,  // data_byte
    input  logic [1:0]                                    s_tuser,  // func
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // out_byte, position, total_length, zero fill
    output logic [((8 + 2 * COUNT_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // has_byte, is_padding, status
    output logic [3:0]                                    m_tuser,
    output logic                                          m_tlast,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [2:0]                                    paddr,
    input  logic [31:0]                                   pwdata,
    output logic [31:0]                                   prdata,
    output logic                                          pready
);

    localparam int TDATA_W = ((8 + 2 * COUNT_BITS + 7) / 8) * 8;

    logic                  in_valid_reg;
    func_t                 in_func_reg;
    logic [7:0]            in_byte_reg;
    logic                  m_tvalid_reg;
    logic [7:0]            out_byte_reg;
    logic [COUNT_BITS-1:0] out_pos_reg;
    logic [COUNT_BITS-1:0] out_total_reg;
    res_flags_t            out_flags_reg;

    logic                  proc_en;
    logic [3:0]            page_size_log2;
    logic [7:0]            res_byte;
    logic [COUNT_BITS-1:0] res_position;
    logic [COUNT_BITS-1:0] res_total;
    res_flags_t            res_flags;

    assign proc_en  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_en;

    lz4bd_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .page_size_log2 (page_size_log2)
    );

    lz4bd_core #(
        .WINDOW_BITS (WINDOW_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .proc_en        (proc_en),
        .func           (in_func_reg),
        .data_byte      (in_byte_reg),
        .page_size_log2 (page_size_log2),
        .res_byte       (res_byte),
        .res_position   (res_position),
        .res_total      (res_total),
        .res_flags      (res_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (proc_en)
            begin
                m_tvalid_reg <= res_flags.valid;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg <= func_t'(s_tuser);
            in_byte_reg <= s_tdata;
        end
        if (proc_en)
        begin
            out_byte_reg  <= res_byte;
            out_pos_reg   <= res_position;
            out_total_reg <= res_total;
            out_flags_reg <= res_flags;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'({out_total_reg, out_pos_reg, out_byte_reg});
    assign m_tuser  = {out_flags_reg.status, out_flags_reg.is_padding, out_flags_reg.has_byte};
    assign m_tlast  = out_flags_reg.done_res;

    `LZ4BD_ASSERT_IMPL(a_result_from_item, $rose(m_tvalid_reg), $past(in_valid_reg), "Result appeared without a pending beat.")
    `LZ4BD_ASSERT_IMPL(a_stall_only_on_output, !s_tready, m_tvalid_reg && !m_tready, "Input stalled while the result register was free.")

endmodule
